FILE: hw/rtl/lpw_pkg.sv
`default_nettype none
package lpw_pkg;

  typedef enum logic [1:0] {
    ACT_CMD    = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_WINDOW = 2'd2,
    ACT_PIXEL  = 2'd3
  } action_t;

  localparam logic [7:0] CMD_COLUMN_ADDR = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR    = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t LAST_STEP_SINGLE = 4'd0;
  localparam step_t LAST_STEP_PIXEL  = 4'd1;
  localparam step_t LAST_STEP_WINDOW = 4'd10;

  // One classified request as it sits in the queue
  typedef struct packed {
    action_t     action;
    logic [7:0]  byte_value;
    logic [15:0] word0;   // x_start, or the pixel
    logic [15:0] word1;   // x_end
    logic [15:0] word2;   // y_start
    logic [15:0] word3;   // y_end
    step_t       last_step;
  } req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lpw_front.sv
`default_nettype none
module lpw_front (
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_action,
  input  wire logic [7:0]    in_byte_value,
  input  wire logic [15:0]   in_x_start,
  input  wire logic [15:0]   in_y_start,
  input  wire logic [15:0]   in_x_end,
  input  wire logic [15:0]   in_y_end,
  input  wire logic [15:0]   in_pixel,
  input  wire logic          q_full,
  output logic               in_ready,
  output logic               push,
  output lpw_pkg::req_t      push_req
);

  lpw_pkg::action_t act;

  assign act      = lpw_pkg::action_t'(in_action);
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_req            = '0;
    push_req.action     = act;
    push_req.byte_value = in_byte_value;
    unique case (act)
      lpw_pkg::ACT_CMD,
      lpw_pkg::ACT_DATA: begin
        push_req.last_step = lpw_pkg::LAST_STEP_SINGLE;
      end
      lpw_pkg::ACT_WINDOW: begin
        push_req.word0     = in_x_start;
        push_req.word1     = in_x_end;
        push_req.word2     = in_y_start;
        push_req.word3     = in_y_end;
        push_req.last_step = lpw_pkg::LAST_STEP_WINDOW;
      end
      lpw_pkg::ACT_PIXEL: begin
        push_req.word0     = in_pixel;
        push_req.last_step = lpw_pkg::LAST_STEP_PIXEL;
      end
      default: begin
        push_req.last_step = lpw_pkg::LAST_STEP_SINGLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lpw_queue.sv
`default_nettype none
module lpw_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lpw_pkg::req_t push_req,
  input  wire logic          pop,
  output logic               full,
  output logic               head_valid,
  output lpw_pkg::req_t      head_req
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lpw_pkg::req_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_req   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lpw_back.sv
`default_nettype none
module lpw_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire lpw_pkg::req_t head_req,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_is_data,
  output logic [7:0]         out_bus_byte,
  output logic               out_last
);

  lpw_pkg::step_t step_r, step_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           is_data_r;
  logic [7:0]     bus_byte_r;
  logic           last_r;

  logic           fire;
  logic           at_last;
  logic           sel_is_data;
  logic [7:0]     sel_byte;

  assign fire    = head_valid && (!out_valid_r || out_ready);
  assign at_last = (step_r == head_req.last_step);
  assign pop     = fire && at_last;

  // Pick the bus byte for the current step of the head request
  always_comb begin
    sel_is_data = 1'b1;
    sel_byte    = head_req.byte_value;
    unique case (head_req.action)
      lpw_pkg::ACT_CMD: begin
        sel_is_data = 1'b0;
      end
      lpw_pkg::ACT_DATA: begin
        sel_is_data = 1'b1;
      end
      lpw_pkg::ACT_PIXEL: begin
        sel_byte = (step_r == '0) ? head_req.word0[15:8] : head_req.word0[7:0];
      end
      lpw_pkg::ACT_WINDOW: begin
        unique case (step_r)
          4'd0: begin
            sel_is_data = 1'b0;
            sel_byte    = lpw_pkg::CMD_COLUMN_ADDR;
          end
          4'd1:    sel_byte = head_req.word0[15:8];
          4'd2:    sel_byte = head_req.word0[7:0];
          4'd3:    sel_byte = head_req.word1[15:8];
          4'd4:    sel_byte = head_req.word1[7:0];
          4'd5: begin
            sel_is_data = 1'b0;
            sel_byte    = lpw_pkg::CMD_ROW_ADDR;
          end
          4'd6:    sel_byte = head_req.word2[15:8];
          4'd7:    sel_byte = head_req.word2[7:0];
          4'd8:    sel_byte = head_req.word3[15:8];
          4'd9:    sel_byte = head_req.word3[7:0];
          default: begin
            sel_is_data = 1'b0;
            sel_byte    = lpw_pkg::CMD_MEM_WRITE;
          end
        endcase
      end
      default: begin
        sel_is_data = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      step_nxt      = at_last ? '0 : step_r + 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the presented byte until the transaction completes
  always_ff @(posedge clk) begin
    if (fire) begin
      is_data_r  <= sel_is_data;
      bus_byte_r <= sel_byte;
      last_r     <= at_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_data  = is_data_r;
  assign out_bus_byte = bus_byte_r;
  assign out_last     = last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/lcd_parallel_window_pixel_writer.sv
`default_nettype none
// The first bus byte of a request is registered in the request queue and then in the output register.
// The output register presents one bus byte per cycle while out_ready stays high; command and data
// give one byte, a pixel two bytes and a window eleven bytes.
// A request queue of QUEUE_DEPTH entries lets new requests in while the sequencer is busy.
// Reset (synchronous, active low) empties the queue and drops any presented byte.
module lcd_parallel_window_pixel_writer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [15:0] in_x_start,
  input  wire logic [15:0] in_y_start,
  input  wire logic [15:0] in_x_end,
  input  wire logic [15:0] in_y_end,
  input  wire logic [15:0] in_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_is_data,
  output logic [7:0]       out_bus_byte,
  output logic             out_last
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          head_valid;
  lpw_pkg::req_t push_req;
  lpw_pkg::req_t head_req;

  lpw_front u_front (
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_pixel      (in_pixel),
    .q_full        (q_full),
    .in_ready      (in_ready),
    .push          (push),
    .push_req      (push_req)
  );

  lpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  lpw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_req     (head_req),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_data  (out_is_data),
    .out_bus_byte (out_bus_byte),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire

FILE: verif/lcd_parallel_window_pixel_writer_checker.sv
`timescale 1ns / 1ps
module lcd_parallel_window_pixel_writer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_x_start,
  input  logic [15:0] in_y_start,
  input  logic [15:0] in_x_end,
  input  logic [15:0] in_y_end,
  input  logic [15:0] in_pixel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_is_data,
  input  logic [7:0]  out_bus_byte,
  input  logic        out_last,
  output int          mismatch_count,
  output int          writes_outstanding
);

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } bus_write_t;

  bus_write_t expected_bus_writes[$];

  task automatic push_bus_write(input logic is_data, input logic [7:0] value,
                                input logic last);
    bus_write_t w;
    w.is_data  = is_data;
    w.bus_byte = value;
    w.last     = last;
    expected_bus_writes.push_back(w);
  endtask

  // high byte first, as the panel expects
  task automatic push_data_word(input logic [15:0] word, input logic last);
    push_bus_write(1'b1, word[15:8], 1'b0);
    push_bus_write(1'b1, word[7:0], last);
  endtask

  task automatic predict_bus_writes(input lpw_pkg::action_t action, input logic [7:0] value,
                                    input logic [15:0] xs, input logic [15:0] ys,
                                    input logic [15:0] xe, input logic [15:0] ye,
                                    input logic [15:0] pix);
    unique case (action)
      lpw_pkg::ACT_CMD: begin
        push_bus_write(1'b0, value, 1'b1);
      end
      lpw_pkg::ACT_DATA: begin
        push_bus_write(1'b1, value, 1'b1);
      end
      lpw_pkg::ACT_WINDOW: begin
        push_bus_write(1'b0, lpw_pkg::CMD_COLUMN_ADDR, 1'b0);
        push_data_word(xs, 1'b0);
        push_data_word(xe, 1'b0);
        push_bus_write(1'b0, lpw_pkg::CMD_ROW_ADDR, 1'b0);
        push_data_word(ys, 1'b0);
        push_data_word(ye, 1'b0);
        push_bus_write(1'b0, lpw_pkg::CMD_MEM_WRITE, 1'b1);
      end
      default: begin
        push_data_word(pix, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    bus_write_t want;
    int errs;
    errs = 0;
    if (rst_n) begin
      // check the output first: a transaction taken at this edge cannot show yet
      if (out_valid && out_ready) begin
        if (expected_bus_writes.size() == 0) begin
          $display("%0t: unexpected bus write, expected none, got is_data=%0b byte=%02h last=%0b",
                   $time, out_is_data, out_bus_byte, out_last);
          errs++;
        end else begin
          want = expected_bus_writes.pop_front();
          if (out_is_data !== want.is_data) begin
            $display("%0t: is_data mismatch, expected %0b, got %0b",
                     $time, want.is_data, out_is_data);
            errs++;
          end
          if (out_bus_byte !== want.bus_byte) begin
            $display("%0t: bus_byte mismatch, expected %02h, got %02h",
                     $time, want.bus_byte, out_bus_byte);
            errs++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, got %0b",
                     $time, want.last, out_last);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_bus_writes(lpw_pkg::action_t'(in_action), in_byte_value, in_x_start,
                           in_y_start, in_x_end, in_y_end, in_pixel);
      end
    end
    mismatch_count     <= mismatch_count + errs;
    writes_outstanding <= expected_bus_writes.size();
  end

endmodule

FILE: verif/lcd_parallel_window_pixel_writer_tb.sv
`timescale 1ns / 1ps
module lcd_parallel_window_pixel_writer_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_RANDOM     = 470;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  lpw_pkg::action_t  in_action = lpw_pkg::ACT_CMD;
  logic [7:0]        in_byte_value = 8'h00;
  logic [15:0]       in_x_start = 16'h0000;
  logic [15:0]       in_y_start = 16'h0000;
  logic [15:0]       in_x_end = 16'h0000;
  logic [15:0]       in_y_end = 16'h0000;
  logic [15:0]       in_pixel = 16'h0000;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_is_data;
  logic [7:0]        out_bus_byte;
  logic              out_last;

  int mismatch_count;
  int writes_outstanding;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit steady_sender = 1'b0;
  bit steady_receiver = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  lcd_parallel_window_pixel_writer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_is_data   (out_is_data),
    .out_bus_byte  (out_bus_byte),
    .out_last      (out_last)
  );

  lcd_parallel_window_pixel_writer_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_byte_value      (in_byte_value),
    .in_x_start         (in_x_start),
    .in_y_start         (in_y_start),
    .in_x_end           (in_x_end),
    .in_y_end           (in_y_end),
    .in_pixel           (in_pixel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_data        (out_is_data),
    .out_bus_byte       (out_bus_byte),
    .out_last           (out_last),
    .mismatch_count     (mismatch_count),
    .writes_outstanding (writes_outstanding)
  );

  // mostly short pauses, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [15:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // returns at the edge where the transaction is taken
  task automatic send_request(input lpw_pkg::action_t action, input logic [7:0] value,
                              input logic [15:0] xs, input logic [15:0] ys,
                              input logic [15:0] xe, input logic [15:0] ye,
                              input logic [15:0] pix);
    int gap;
    gap = 0;
    if (!steady_sender && $urandom_range(0, 3) == 0) gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= action;
    in_byte_value <= value;
    in_x_start    <= xs;
    in_y_start    <= ys;
    in_x_end      <= xe;
    in_y_end      <= ye;
    in_pixel      <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every predicted bus write has come out
  task automatic drain_bus_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (writes_outstanding != 0) @(posedge clk);
  endtask

  task automatic send_simple(input lpw_pkg::action_t action, input logic [7:0] value);
    send_request(action, value, rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word());
  endtask

  task automatic send_pixel(input logic [15:0] pix);
    send_request(lpw_pkg::ACT_PIXEL, 8'($urandom_range(0, 255)), rand_word(), rand_word(),
                 rand_word(), rand_word(), pix);
  endtask

  task automatic send_window(input logic [15:0] xs, input logic [15:0] ys,
                             input logic [15:0] xe, input logic [15:0] ye);
    send_request(lpw_pkg::ACT_WINDOW, 8'($urandom_range(0, 255)), xs, ys, xe, ye,
                 rand_word());
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady_receiver && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(0, 99) == 0) steady_receiver <= !steady_receiver;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL lcd_parallel_window_pixel_writer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_simple(lpw_pkg::ACT_CMD, 8'h00);
    send_simple(lpw_pkg::ACT_CMD, 8'hFF);
    send_simple(lpw_pkg::ACT_CMD, lpw_pkg::CMD_COLUMN_ADDR);
    send_simple(lpw_pkg::ACT_CMD, lpw_pkg::CMD_MEM_WRITE);
    send_simple(lpw_pkg::ACT_DATA, 8'h00);
    send_simple(lpw_pkg::ACT_DATA, 8'hFF);
    send_simple(lpw_pkg::ACT_DATA, 8'hA5);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h00FF);
    send_pixel(16'hFF00);
    send_pixel(16'h8001);
    send_window(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_window(16'h0102, 16'h0506, 16'h0304, 16'h0708);
    // start beyond end is passed through unchanged
    send_window(16'hFFFF, 16'h1234, 16'h0000, 16'h0001);
    send_window(16'h0000, 16'h013F, 16'h00EF, 16'h0000);
    send_pixel(16'h5A5A);
    send_simple(lpw_pkg::ACT_CMD, lpw_pkg::CMD_ROW_ADDR);
    drain_bus_writes();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 39) == 0) steady_sender = !steady_sender;
      if (i == NUM_RANDOM / 2) drain_bus_writes();
      r = $urandom_range(0, 99);
      if (r < 45) send_pixel(rand_word());
      else if (r < 65) send_window(rand_word(), rand_word(), rand_word(), rand_word());
      else if (r < 82) send_simple(lpw_pkg::ACT_DATA, 8'($urandom_range(0, 255)));
      else send_simple(lpw_pkg::ACT_CMD, 8'($urandom_range(0, 255)));
    end

    drain_bus_writes();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS lcd_parallel_window_pixel_writer");
    end else begin
      $display("FAIL lcd_parallel_window_pixel_writer");
    end
    $finish;
  end

endmodule

FILE: lcd_parallel_window_pixel_writer.f
hw/rtl/lpw_pkg.sv
hw/rtl/lpw_front.sv
hw/rtl/lpw_queue.sv
hw/rtl/lpw_back.sv
hw/rtl/lcd_parallel_window_pixel_writer.sv
verif/lcd_parallel_window_pixel_writer_checker.sv
verif/lcd_parallel_window_pixel_writer_tb.sv
